FILE: sv/battery_level_average_and_alarm_defines.svh
// Assertion macros for the battery level averaging block checker.
`ifndef BATTERY_LEVEL_AVERAGE_AND_ALARM_DEFINES_SVH
`define BATTERY_LEVEL_AVERAGE_AND_ALARM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BATAVG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BATAVG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/batavg_pkg.sv
// Shared constants, codes and stage types of the battery level averaging block.
`timescale 1ns / 1ps
package batavg_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int AVG_W      = 9;
	localparam int URG_W      = 2;
	localparam int PCT_W      = 9;
	localparam int PCT_MAG_W  = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MID  = 2'd2;

	localparam logic [CFG_W-1:0] HIGH_RST = 12'd3300;
	localparam logic [CFG_W-1:0] LOW_RST  = 12'd2290;
	localparam logic [CFG_W-1:0] MID_RST  = 12'd2750;

	// urgency codes
	localparam logic [URG_W-1:0] URG_NORMAL = 2'd0;
	localparam logic [URG_W-1:0] URG_HIGH   = 2'd1;
	localparam logic [URG_W-1:0] URG_URGENT = 2'd2;

	// percentage scaling: 100*(sample-2290)/917 via reciprocal
	localparam int PCT_OFFSET  = 2290;
	localparam int PCT_FULL    = 3207;
	localparam int PCT_SCALE   = 100;
	localparam int PCT_DEN     = PCT_FULL - PCT_OFFSET;
	localparam int PCT_SHIFT   = 28;
	localparam int PCT_RECIP   = ((1 << PCT_SHIFT) + PCT_DEN - 1) / PCT_DEN;
	localparam int PCT_K_W     = 25;
	localparam logic [PCT_K_W-1:0] PCT_K = PCT_K_W'(PCT_SCALE * PCT_RECIP);
	localparam int PCT_MAG_MAX = (PCT_SCALE * PCT_OFFSET) / PCT_DEN;

	localparam int AVG_MIN = -PCT_MAG_MAX;
	localparam int AVG_MAX = (PCT_SCALE * ((1 << SAMPLE_W) - 1 - PCT_OFFSET)) / PCT_DEN;

	localparam logic signed [PCT_W-1:0] PCT_INIT = PCT_W'(PCT_SCALE);

	localparam int WINDOW_SIZE_DEF = 8;

	// scaled percentage on its way to the window store
	typedef struct packed {
		logic                 vld;
		logic                 neg;
		logic [PCT_MAG_W-1:0] mag;
		logic [URG_W-1:0]     urg;
	} batavg_pct_t;

	// stage control behind the window store
	typedef struct packed {
		logic             vld;
		logic [URG_W-1:0] urg;
	} batavg_ctl_t;

endpackage

FILE: sv/batavg_ifs.sv
// Valid/ready channel interfaces for sample and result words.
`timescale 1ns / 1ps
interface batavg_in_if import batavg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface batavg_out_if import batavg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [AVG_W-1:0] average_percent;
	logic [URG_W-1:0]        urgency;

	modport source (output valid, output average_percent, output urgency, input ready);
	modport sink (input valid, input average_percent, input urgency, output ready);
endinterface

FILE: sv/batavg_scale.sv
// Input register, percentage scaling and urgency classification.
`timescale 1ns / 1ps
module batavg_scale import batavg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [CFG_W-1:0]    high_limit,
	input  logic [CFG_W-1:0]    low_limit,
	input  logic [CFG_W-1:0]    mid_limit,
	output batavg_pct_t         pct_s2
);

	localparam int PROD_W = SAMPLE_W + PCT_K_W;

	logic                vld_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                neg;
	logic [SAMPLE_W-1:0] absd;
	logic [PROD_W-1:0]   prod;
	logic [URG_W-1:0]    urg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1 <= sample;
		end
	end

	// |sample - offset| * 100 * ceil(2^28/917) >> 28 is exact over the 12-bit range
	always_comb begin
		neg  = sample_s1 < SAMPLE_W'(PCT_OFFSET);
		absd = neg ? SAMPLE_W'(PCT_OFFSET) - sample_s1 : sample_s1 - SAMPLE_W'(PCT_OFFSET);
		prod = PROD_W'(absd) * PROD_W'(PCT_K);
	end

	// checks in priority order
	always_comb begin
		if (sample_s1 > high_limit) begin
			urg = URG_URGENT;
		end else if (sample_s1 < low_limit) begin
			urg = URG_URGENT;
		end else if (sample_s1 >= mid_limit) begin
			urg = URG_NORMAL;
		end else begin
			urg = URG_HIGH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_s2 <= '0;
		end else if (en) begin
			pct_s2.vld <= vld_s1;
			pct_s2.neg <= neg;
			pct_s2.mag <= prod[PCT_SHIFT +: PCT_MAG_W];
			pct_s2.urg <= urg;
		end
	end

endmodule

FILE: sv/batavg_window.sv
// Percentage window store with read-modify-write of the running sum.
`timescale 1ns / 1ps
module batavg_window import batavg_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  batavg_pct_t                            pct_s2,
	output batavg_ctl_t                            ctl_s3,
	output logic signed [$clog2(PCT_MAG_MAX*WINDOW_SIZE+1):0] sum_s3
);

	localparam int SUM_W = $clog2(PCT_MAG_MAX * WINDOW_SIZE + 1) + 1;
	localparam int PTR_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_SIZE - 1);

	logic signed [PCT_W-1:0] mem [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0]  vld_q;
	logic [PTR_W-1:0]        ptr_q;
	logic [PTR_W-1:0]        ptr_nxt;
	logic [PTR_W-1:0]        rd_addr;
	logic                    wr;
	logic signed [PCT_W-1:0] rdata_q;
	logic                    rvld_q;
	logic                    fwd_q;
	logic signed [PCT_W-1:0] fdat_q;
	logic signed [PCT_W-1:0] pct_val;
	logic signed [PCT_W-1:0] old_val;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_nxt;

	// ptr_q is the entry of the word in stage 2; the word entering reads the one after
	always_comb begin
		wr      = en && pct_s2.vld;
		ptr_nxt = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
		rd_addr = wr ? ptr_nxt : ptr_q;
		pct_val = pct_s2.neg ? -$signed({1'b0, pct_s2.mag}) : $signed({1'b0, pct_s2.mag});
		// same-entry write in the read cycle (window of one) is forwarded
		old_val = fwd_q ? fdat_q : (rvld_q ? rdata_q : PCT_INIT);
		sum_nxt = sum_q - SUM_W'(old_val) + SUM_W'(pct_val);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr) begin
			mem[ptr_q] <= pct_val;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fdat_q <= pct_val;
			sum_s3 <= sum_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			ptr_q  <= '0;
			sum_q  <= SUM_W'(PCT_SCALE * WINDOW_SIZE);
			rvld_q <= 1'b0;
			fwd_q  <= 1'b0;
			ctl_s3 <= '0;
		end else begin
			if (wr) begin
				vld_q[ptr_q] <= 1'b1;
				ptr_q        <= ptr_nxt;
				sum_q        <= sum_nxt;
			end
			if (en) begin
				rvld_q     <= vld_q[rd_addr];
				fwd_q      <= wr && (rd_addr == ptr_q);
				ctl_s3.vld <= pct_s2.vld;
				ctl_s3.urg <= pct_s2.urg;
			end
		end
	end

endmodule

FILE: sv/batavg_avg.sv
// Window sum to average (truncating divide by the window size) and output register.
`timescale 1ns / 1ps
module batavg_avg import batavg_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  batavg_ctl_t                            ctl_s3,
	input  logic signed [$clog2(PCT_MAG_MAX*WINDOW_SIZE+1):0] sum_s3,
	output logic                                   out_vld_q,
	output logic signed [AVG_W-1:0]                avg_q,
	output logic [URG_W-1:0]                       urg_q
);

	localparam int SUM_W     = $clog2(PCT_MAG_MAX * WINDOW_SIZE + 1) + 1;
	localparam int MAG_W     = SUM_W - 1;
	localparam int DIV_SHIFT = MAG_W + $clog2(WINDOW_SIZE) + 1;
	localparam int RECIP_W   = DIV_SHIFT + 1;
	localparam logic [RECIP_W-1:0] DIV_RECIP =
		RECIP_W'(((64'd1 << DIV_SHIFT) + WINDOW_SIZE - 1) / WINDOW_SIZE);
	localparam int PROD_W    = MAG_W + RECIP_W;

	logic                 neg;
	logic [MAG_W-1:0]     mag;
	logic [PROD_W-1:0]    prod;
	logic [PCT_MAG_W-1:0] quo;
	logic signed [AVG_W-1:0] avg;

	// magnitude times ceil(2^S/W) >> S is exact for every reachable sum
	always_comb begin
		neg  = sum_s3[SUM_W-1];
		mag  = neg ? MAG_W'(-sum_s3) : MAG_W'(sum_s3);
		prod = PROD_W'(mag) * PROD_W'(DIV_RECIP);
		quo  = prod[DIV_SHIFT +: PCT_MAG_W];
		avg  = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= ctl_s3.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			avg_q <= avg;
			urg_q <= ctl_s3.urg;
		end
	end

endmodule

FILE: sv/battery_level_average_and_alarm.sv
// A word accepted into the sample register passes the s2 and s3 registers to the output register.
// Throughput: one sample word per cycle unless stalled, set by one window read and write a cycle.
// The whole pipe advances together; a held result stalls it and drops sample ready.
// Reset (arst_n low, asynchronous): limits to 3300/2290/2750, window reads as 100,
// running sum 100 * WINDOW_SIZE, write position 0, pipe empty. No clearing pass.
`timescale 1ns / 1ps
module battery_level_average_and_alarm import batavg_pkg::*; #(
	parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	batavg_in_if.sink            sample_ch,
	batavg_out_if.source         result_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int SUM_W = $clog2(PCT_MAG_MAX * WINDOW_SIZE + 1) + 1;

	// Stages:
	//   s1  sample register
	//   s2  scaled magnitude and urgency; window entry read lands here
	//   s3  running sum after replacing the oldest entry
	//   out average and urgency held for the sink
	// Valid bits on the window store stand in for the reset fill of 100.

	logic [CFG_W-1:0]        high_limit_q;
	logic [CFG_W-1:0]        low_limit_q;
	logic [CFG_W-1:0]        mid_limit_q;
	logic                    en;
	batavg_pct_t             pct_s2;
	batavg_ctl_t             ctl_s3;
	logic signed [SUM_W-1:0] sum_s3;
	logic                    out_vld_q;
	logic signed [AVG_W-1:0] avg_q;
	logic [URG_W-1:0]        urg_q;

	// config registers; unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_limit_q <= HIGH_RST;
			low_limit_q  <= LOW_RST;
			mid_limit_q  <= MID_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HIGH: high_limit_q <= cfg_data;
				REG_LOW:  low_limit_q  <= cfg_data;
				REG_MID:  mid_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipe moves whenever the output slot is free or being emptied
	assign en              = !out_vld_q || result_ch.ready;
	assign sample_ch.ready = en;

	batavg_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (sample_ch.valid),
		.sample     (sample_ch.sample),
		.high_limit (high_limit_q),
		.low_limit  (low_limit_q),
		.mid_limit  (mid_limit_q),
		.pct_s2     (pct_s2)
	);

	batavg_window #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.pct_s2 (pct_s2),
		.ctl_s3 (ctl_s3),
		.sum_s3 (sum_s3)
	);

	batavg_avg #(
		.WINDOW_SIZE (WINDOW_SIZE)
	) u_avg (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_s3    (ctl_s3),
		.sum_s3    (sum_s3),
		.out_vld_q (out_vld_q),
		.avg_q     (avg_q),
		.urg_q     (urg_q)
	);

	assign result_ch.valid           = out_vld_q;
	assign result_ch.average_percent = avg_q;
	assign result_ch.urgency         = urg_q;

endmodule

FILE: sv/batavg_chk.sv
// Port-level checker for the battery level averaging block, bound to the top level.
`timescale 1ns / 1ps
`include "battery_level_average_and_alarm_defines.svh"
module batavg_chk import batavg_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [AVG_W-1:0] avg,
	input logic [URG_W-1:0]        urg
);

	// a sink that takes words never throttles the source
	`BATAVG_ASSERT_IMP(a_no_bubble, out_ready, in_ready, "sample ready low while result sink ready")

	// an accepted word reaches the result channel when the sink keeps up
	`BATAVG_ASSERT_NXT(a_latency, in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid, "result word missing three cycles after accept")

	`BATAVG_ASSERT_IMP(a_avg_range, out_valid, avg >= AVG_MIN && avg <= AVG_MAX, "average out of range")

	`BATAVG_ASSERT_IMP(a_urg_code, out_valid, urg == URG_NORMAL || urg == URG_HIGH || urg == URG_URGENT, "reserved urgency code")

	`BATAVG_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(avg) && $stable(urg), "stalled result word changed")

endmodule

bind battery_level_average_and_alarm batavg_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample_ch.valid),
	.in_ready  (sample_ch.ready),
	.out_valid (result_ch.valid),
	.out_ready (result_ch.ready),
	.avg       (result_ch.average_percent),
	.urg       (result_ch.urgency)
);
